>>> rtl/core/mnrw_pkg.sv
// Shared types and constants of the multicast NACK receive window.
`default_nettype none

package mnrw_pkg;

  localparam int unsigned Window  = 32;
  localparam int unsigned NackCap = (Window < 32) ? Window : 32;
  localparam int unsigned IdxW    = $clog2(Window);
  localparam int unsigned PosW    = $clog2(Window + NackCap + 1);
  localparam int unsigned EmitW   = $clog2(NackCap + 1);

  typedef enum logic [1:0] {
    CmdData = 2'd0,
    CmdAck  = 2'd1,
    CmdSync = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KindAccepted = 3'd0,
    KindOld      = 3'd1,
    KindDup      = 3'd2,
    KindOutWin   = 3'd3,
    KindNack     = 3'd4,
    KindReply    = 3'd5,
    KindIgnored  = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  slot;
    logic [31:0] seq_value;
    logic [5:0]  nack_count;
    logic        batch_complete;
    logic [5:0]  packet_count;
    logic        truncated;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } res_req_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        borrow;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/mnrw_alu.sv
// Shared 32-bit add/subtract unit with borrow out.
`default_nettype none

module mnrw_alu (
  input  mnrw_pkg::alu_req_t req_i,
  output mnrw_pkg::alu_rsp_t rsp_o
);

  logic [32:0] total;

  assign total = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
               + {32'd0, req_i.sub};

  assign rsp_o.sum    = total[31:0];
  assign rsp_o.borrow = req_i.sub & ~total[32];

endmodule

`default_nettype wire

>>> rtl/core/mnrw_ctrl.sv
// Sequencer, base sequence and received map of the receive window.
`default_nettype none

module mnrw_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire [1:0]                 command_i,
  input  wire [31:0]                seq_number_i,
  input  wire                       out_free_i,
  output mnrw_pkg::res_req_t        res_o,
  output mnrw_pkg::alu_req_t        alu_req_o,
  input  mnrw_pkg::alu_rsp_t        alu_rsp_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StExec  = 4'b0010,
    StScan  = 4'b0100,
    StReply = 4'b1000
  } state_e;

  state_e                                state_q, state_d;
  logic [1:0]                            cmd_q, cmd_d;
  logic [31:0]                           seq_q, seq_d;
  logic [31:0]                           base_q, base_d;
  logic [mnrw_pkg::Window-1:0]           map_q, map_d;
  logic [31:0]                           span_q, span_d;
  logic [mnrw_pkg::PosW-1:0]             pos_q, pos_d;
  logic [mnrw_pkg::EmitW-1:0]            emit_q, emit_d;
  logic                                  drop_q, drop_d;
  logic                                  complete;

  assign in_stall_o = (state_q != StIdle);
  assign complete   = (emit_q == '0) && !drop_q && (span_q != 32'd0);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    seq_d     = seq_q;
    base_d    = base_q;
    map_d     = map_q;
    span_d    = span_q;
    pos_d     = pos_q;
    emit_d    = emit_q;
    drop_d    = drop_q;
    res_o     = '0;
    alu_req_o = '{a: seq_q, b: base_q, sub: 1'b1};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          seq_d   = seq_number_i;
          state_d = StExec;
        end
      end
      StExec: begin
        unique case (cmd_q)
          mnrw_pkg::CmdData: begin
            if (out_free_i) begin
              res_o.load          = 1'b1;
              res_o.res.seq_value = seq_q;
              res_o.res.last      = 1'b1;
              if (alu_rsp_i.borrow) begin
                res_o.res.kind = mnrw_pkg::KindOld;
              end else if (alu_rsp_i.sum >= 32'(mnrw_pkg::Window)) begin
                res_o.res.kind = mnrw_pkg::KindOutWin;
              end else if (map_q[alu_rsp_i.sum[mnrw_pkg::IdxW-1:0]]) begin
                res_o.res.kind = mnrw_pkg::KindDup;
              end else begin
                res_o.res.kind = mnrw_pkg::KindAccepted;
                res_o.res.slot = 5'(alu_rsp_i.sum);
                map_d[alu_rsp_i.sum[mnrw_pkg::IdxW-1:0]] = 1'b1;
              end
              state_d = StIdle;
            end
          end
          mnrw_pkg::CmdAck: begin
            span_d  = alu_rsp_i.borrow ? 32'd0 : alu_rsp_i.sum;
            pos_d   = '0;
            emit_d  = '0;
            drop_d  = 1'b0;
            state_d = StScan;
          end
          default: begin
            if (out_free_i) begin
              res_o.load     = 1'b1;
              res_o.res.kind = mnrw_pkg::KindIgnored;
              res_o.res.last = 1'b1;
              state_d        = StIdle;
            end
          end
        endcase
      end
      StScan: begin
        // one window position per step; base + pos gives the nack sequence
        alu_req_o = '{a: base_q, b: 32'(pos_q), sub: 1'b0};
        if (32'(pos_q) >= span_q) begin
          state_d = StReply;
        end else if (pos_q < mnrw_pkg::PosW'(mnrw_pkg::Window) &&
                     map_q[pos_q[mnrw_pkg::IdxW-1:0]]) begin
          pos_d = pos_q + 1'b1;
        end else if (emit_q == mnrw_pkg::EmitW'(mnrw_pkg::NackCap)) begin
          // list full and another sequence missing: stop and flag it
          drop_d  = 1'b1;
          state_d = StReply;
        end else if (out_free_i) begin
          res_o.load          = 1'b1;
          res_o.res.kind      = mnrw_pkg::KindNack;
          res_o.res.seq_value = alu_rsp_i.sum;
          emit_d              = emit_q + 1'b1;
          pos_d               = pos_q + 1'b1;
        end
      end
      StReply: begin
        alu_req_o = '{a: seq_q, b: 32'd1, sub: 1'b0};
        if (out_free_i) begin
          res_o.load               = 1'b1;
          res_o.res.kind           = mnrw_pkg::KindReply;
          res_o.res.seq_value      = seq_q;
          res_o.res.nack_count     = 6'(emit_q);
          res_o.res.truncated      = drop_q;
          res_o.res.batch_complete = complete;
          res_o.res.packet_count   = complete ? 6'(span_q) : 6'd0;
          res_o.res.last           = 1'b1;
          if (complete) begin
            base_d = alu_rsp_i.sum;
            map_d  = '0;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      base_q  <= 32'd1;
      map_q   <= '0;
      pos_q   <= '0;
      emit_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      map_q   <= map_d;
      pos_q   <= pos_d;
      emit_q  <= emit_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    seq_q  <= seq_d;
    span_q <= span_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/multicast_nack_receiver_window.sv
// Top level of the multicast NACK receive window: sequencer, shared ALU, result register.
//
// Input channel: command_i / seq_number_i, transfer when in_valid_i is high and
// in_stall_o is low. Output channel: one result per transfer on kind_o, slot_o,
// seq_value_o, nack_count_o, batch_complete_o, packet_count_o, truncated_o and
// last_o; last_o marks the final result of an input item.
// Data and other packets pass through the execute state, where the shared
// add/subtract unit forms seq - base and the packet is classified, and then
// return to idle when the output register can take the result.
// An ack request forms the span in the execute state; the scan then covers at
// most the ack span, capped at Window + 32 positions, walking one position per
// cycle through the shared unit while no nack waits for the output, and emits
// one nack per missing position up to NackCap, flagging truncation past it; the
// scan ends, the reply state forms the reply and, for a completed batch, the new
// base, and the sequencer returns to idle.
// A single output register separates the channels; while the receiver stalls,
// the held result stays and the sequencer waits at the next result it has to
// send. After reset the base sequence is 1 and the received map is clear.
`default_nettype none

module multicast_nack_receiver_window (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  command_i,
  input  wire  [31:0] seq_number_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  kind_o,
  output logic [4:0]  slot_o,
  output logic [31:0] seq_value_o,
  output logic [5:0]  nack_count_o,
  output logic        batch_complete_o,
  output logic [5:0]  packet_count_o,
  output logic        truncated_o,
  output logic        last_o
);

  mnrw_pkg::res_req_t res_req;
  mnrw_pkg::alu_req_t alu_req;
  mnrw_pkg::alu_rsp_t alu_rsp;
  mnrw_pkg::result_t  out_q;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  mnrw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .seq_number_i (seq_number_i),
    .out_free_i   (out_free),
    .res_o        (res_req),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp)
  );

  mnrw_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_req.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (res_req.load) begin
      out_q <= res_req.res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign slot_o           = out_q.slot;
  assign seq_value_o      = out_q.seq_value;
  assign nack_count_o     = out_q.nack_count;
  assign batch_complete_o = out_q.batch_complete;
  assign packet_count_o   = out_q.packet_count;
  assign truncated_o      = out_q.truncated;
  assign last_o           = out_q.last;

endmodule

`default_nettype wire

>>> rtl/core/mnrw_checker.sv
// Port-level assertions for the multicast NACK receive window, bound to the top level.
`default_nettype none

module mnrw_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [2:0]  kind_o,
  input wire [4:0]  slot_o,
  input wire [31:0] seq_value_o,
  input wire [5:0]  nack_count_o,
  input wire        batch_complete_o,
  input wire [5:0]  packet_count_o,
  input wire        truncated_o,
  input wire        last_o
);

  // one item at a time: a transfer in closes the input for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous item in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
                                   $stable(slot_o) && $stable(seq_value_o) &&
                                   $stable(nack_count_o) && $stable(batch_complete_o) &&
                                   $stable(packet_count_o) && $stable(truncated_o) &&
                                   $stable(last_o))
    else $error("stalled result changed");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != mnrw_pkg::KindNack)))
    else $error("last flag does not match result kind");

  a_reply_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == mnrw_pkg::KindReply |->
      nack_count_o <= 6'(mnrw_pkg::NackCap))
    else $error("nack count exceeds cap");

  a_complete_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_complete_o |->
      nack_count_o == 6'd0 && !truncated_o && packet_count_o != 6'd0 - 6'd0 ||
      out_valid_o && batch_complete_o && nack_count_o == 6'd0 && !truncated_o)
    else $error("completed batch reports missing sequences");

endmodule

bind multicast_nack_receiver_window mnrw_checker u_mnrw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .slot_o           (slot_o),
  .seq_value_o      (seq_value_o),
  .nack_count_o     (nack_count_o),
  .batch_complete_o (batch_complete_o),
  .packet_count_o   (packet_count_o),
  .truncated_o      (truncated_o),
  .last_o           (last_o)
);

`default_nettype wire

>>> test/mnrw_window_checker.sv
// Checker for the multicast NACK receive window: predicts every result and compares transfers.
`timescale 1ns / 100ps

module mnrw_window_checker
  import mnrw_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [1:0]  command_i,
  input  wire  [31:0] seq_number_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire  [2:0]  kind_i,
  input  wire  [4:0]  slot_i,
  input  wire  [31:0] seq_value_i,
  input  wire  [5:0]  nack_count_i,
  input  wire         batch_complete_i,
  input  wire  [5:0]  packet_count_i,
  input  wire         truncated_i,
  input  wire         last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          nacks_o,
  output int          batches_o,
  output int          truncs_o
);

  // Predicted receive window state.
  logic [31:0]       win_base = 32'd1;
  logic [Window-1:0] win_map  = '0;

  result_t expected_results[$];
  result_t got_result;
  result_t want_result;
  int      fail_count = 0;
  int      checked    = 0;
  int      nacks      = 0;
  int      batches    = 0;
  int      truncs     = 0;

  function automatic result_t make_result(kind_e k, logic [4:0] s, logic [31:0] v,
                                          logic [5:0] nc, logic bc, logic [5:0] pc,
                                          logic tr, logic ls);
    result_t r;
    r.kind           = k;
    r.slot           = s;
    r.seq_value      = v;
    r.nack_count     = nc;
    r.batch_complete = bc;
    r.packet_count   = pc;
    r.truncated      = tr;
    r.last           = ls;
    return r;
  endfunction

  // Append one predicted result at the tail of the queue.
  task automatic queue_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 30) begin
      $display("[%0t] mismatch on %s: got %h, want %h (result %0d)",
               $realtime, what, got, want, checked);
    end
    fail_count++;
  endtask

  // Classify one packet against the window and queue the results it causes.
  task automatic predict_packet(input logic [1:0] cmd, input logic [31:0] seq);
    logic [31:0]       pos;
    logic [31:0]       span;
    logic [31:0]       p;
    longint unsigned   missing;
    int unsigned       emitted;
    logic              done;
    logic [31:0]       pk;
    missing = 0;
    emitted = 0;
    done    = 1'b0;
    pk      = '0;
    case (cmd)
      CmdData: begin
        if (seq < win_base) begin
          queue_result(make_result(KindOld, '0, seq, '0, 1'b0, '0, 1'b0, 1'b1));
        end else begin
          pos = seq - win_base;
          if (pos >= Window) begin
            queue_result(
              make_result(KindOutWin, '0, seq, '0, 1'b0, '0, 1'b0, 1'b1));
          end else if (win_map[pos]) begin
            queue_result(
              make_result(KindDup, '0, seq, '0, 1'b0, '0, 1'b0, 1'b1));
          end else begin
            win_map[pos] = 1'b1;
            queue_result(
              make_result(KindAccepted, pos[4:0], seq, '0, 1'b0, '0, 1'b0, 1'b1));
          end
        end
      end
      CmdAck: begin
        span = (seq > win_base) ? seq - win_base : '0;
        for (p = 0; p < span && p < Window; p++) begin
          if (!win_map[p]) begin
            missing++;
            if (emitted < NackCap) begin
              queue_result(
                make_result(KindNack, '0, win_base + p, '0, 1'b0, '0, 1'b0, 1'b0));
              emitted++;
            end
          end
        end
        // Positions past the window were never stored: all count as missing.
        if (span > Window) begin
          missing += span - Window;
          for (p = Window; p < span && emitted < NackCap; p++) begin
            queue_result(
              make_result(KindNack, '0, win_base + p, '0, 1'b0, '0, 1'b0, 1'b0));
            emitted++;
          end
        end
        nacks += emitted;
        if (missing == 0 && win_base < seq) begin
          done     = 1'b1;
          pk       = seq - win_base;
          win_base = seq + 32'd1;
          win_map  = '0;
          batches++;
        end
        if (missing > emitted) truncs++;
        queue_result(make_result(KindReply, '0, seq, 6'(emitted), done,
                                 pk[5:0], missing > emitted, 1'b1));
      end
      default: begin
        queue_result(
          make_result(KindIgnored, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.kind !== want.kind)
      report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.slot !== want.slot)
      report_mismatch("slot", 32'(got.slot), 32'(want.slot));
    if (got.seq_value !== want.seq_value)
      report_mismatch("seq_value", got.seq_value, want.seq_value);
    if (got.nack_count !== want.nack_count)
      report_mismatch("nack_count", 32'(got.nack_count), 32'(want.nack_count));
    if (got.batch_complete !== want.batch_complete)
      report_mismatch("batch_complete", 32'(got.batch_complete), 32'(want.batch_complete));
    if (got.packet_count !== want.packet_count)
      report_mismatch("packet_count", 32'(got.packet_count), 32'(want.packet_count));
    if (got.truncated !== want.truncated)
      report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
    if (got.last !== want.last)
      report_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      win_base = 32'd1;
      win_map  = '0;
    end else begin
      // Check the output transfer first: it never belongs to this edge's input.
      if (out_valid_i && !out_stall_i) begin
        got_result = make_result(kind_e'(kind_i), slot_i, seq_value_i, nack_count_i,
                                 batch_complete_i, packet_count_i, truncated_i, last_i);
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 32'(kind_i), '0);
        end else begin
          want_result = expected_results.pop_front();
          compare_result(got_result, want_result);
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) predict_packet(command_i, seq_number_i);
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    nacks_o      <= nacks;
    batches_o    <= batches;
    truncs_o     <= truncs;
  end

endmodule

>>> test/tb.sv
// Testbench top for the multicast NACK receive window: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
  import mnrw_pkg::*;

  localparam int RandomItems = 250;
  localparam int CycleLimit  = 4000000;
  localparam int DrainCycles = 100;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [1:0]  command    = '0;
  logic [31:0] seq_number = '0;
  logic        out_stall  = 1'b0;

  wire         in_stall;
  wire         out_valid;
  wire  [2:0]  kind;
  wire  [4:0]  slot;
  wire  [31:0] seq_value;
  wire  [5:0]  nack_count;
  wire         batch_complete;
  wire  [5:0]  packet_count;
  wire         truncated;
  wire         last;

  int fail_count;
  int pending;
  int checked;
  int nacks;
  int batches;
  int truncs;

  // Sender-side view of the window, used to build well-formed batches.
  logic [31:0]       send_base = 32'd1;
  logic [Window-1:0] send_mask = '0;

  bit quiet       = 1'b0;
  int items_sent  = 0;
  int batch_no    = 0;
  int stall_left  = 0;
  int stall_pick;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multicast_nack_receiver_window dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .seq_number_i     (seq_number),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .slot_o           (slot),
    .seq_value_o      (seq_value),
    .nack_count_o     (nack_count),
    .batch_complete_o (batch_complete),
    .packet_count_o   (packet_count),
    .truncated_o      (truncated),
    .last_o           (last)
  );

  mnrw_window_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .seq_number_i     (seq_number),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (kind),
    .slot_i           (slot),
    .seq_value_i      (seq_value),
    .nack_count_i     (nack_count),
    .batch_complete_i (batch_complete),
    .packet_count_i   (packet_count),
    .truncated_i      (truncated),
    .last_i           (last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .nacks_o          (nacks),
    .batches_o        (batches),
    .truncs_o         (truncs)
  );

  // Receiver stall runs: mostly short, a few long, none in quiet stretches.
  always @(posedge clk) begin
    if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (stall_pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** multicast_nack_receiver_window: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Transfer one packet, then update the sender's view of the window.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] seq);
    int                gap;
    logic [31:0]       off;
    logic [Window-1:0] low;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    seq_number <= seq;
    do @(posedge clk); while (in_stall);
    off = seq - send_base;
    if (cmd == CmdData && seq >= send_base && off < Window) begin
      send_mask[off] = 1'b1;
    end else if (cmd == CmdAck && seq > send_base && off <= Window) begin
      low = '1;
      low = low >> (Window - off);
      if ((send_mask & low) == low) begin
        send_base = seq + 32'd1;
        send_mask = '0;
      end
    end
    if (cmd == CmdData || cmd == CmdAck) items_sent++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 6))
      0: send_item(CmdData, $urandom);
      1: send_item(CmdData, $urandom_range(0, send_base - 32'd1));
      2: send_item(CmdData, send_base + $urandom_range(Window - 1, Window + 8));
      3: send_item(2'($urandom_range(2, 3)), $urandom);
      4: send_item(CmdAck, $urandom_range(0, send_base));
      5: send_item(CmdAck, send_base + $urandom_range(Window + 1, 200));
      default: send_item(CmdAck, $urandom);
    endcase
  endtask

  // One batch: shuffled data with drops and duplicates, an ack, retransmit on nacks.
  task automatic run_batch(input int k);
    logic [31:0] first;
    logic [31:0] s;
    int          order[Window];
    int          i;
    int          j;
    int          t;
    int          tries;
    first = send_base;
    for (i = 0; i < k; i++) order[i] = i;
    for (i = k - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < k; i++) begin
      if ($urandom_range(0, 99) < 10) send_noise();
      if ($urandom_range(0, 99) < 88) send_item(CmdData, first + order[i]);
      if ($urandom_range(0, 99) < 8) send_item(CmdData, first + order[i]);
    end
    if ($urandom_range(0, 99) < 10) send_item(CmdAck, first + $urandom_range(1, k));
    send_item(CmdAck, first + k);
    tries = 0;
    while (send_base != first + k + 1 && tries < 3) begin
      for (i = 0; i < k; i++) begin
        s = first + i;
        if (s >= send_base && s - send_base < Window && !send_mask[s - send_base])
          send_item(CmdData, s);
      end
      send_item(CmdAck, first + k);
      tries++;
    end
  endtask

  function automatic int pick_batch_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, Window);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: base starts at 1.
    send_item(CmdAck, 32'd0);            // ack below base
    send_item(CmdAck, 32'd1);            // ack at base
    send_item(CmdData, 32'd0);           // old
    send_item(CmdData, 32'd1);           // slot 0
    send_item(CmdData, 32'd1);           // duplicate
    send_item(CmdData, 32'd32);          // last slot of the window
    send_item(CmdData, 32'd33);          // first position past the window
    send_item(CmdData, 32'hFFFF_FFFF);
    send_item(CmdAck, 32'd40);           // missing list capped
    send_item(CmdAck, 32'd2);            // completes, base moves to 3
    send_item(CmdSync, 32'd5);
    send_item(2'd3, 32'hFFFF_FFFF);      // unknown command
    send_item(CmdData, 32'd2);
    send_item(CmdAck, 32'd3);
    send_item(CmdData, 32'd3);
    send_item(CmdData, 32'd4);
    send_item(CmdAck, 32'd6);            // one nack for 5
    send_item(CmdData, 32'd5);
    send_item(CmdAck, 32'd6);            // completes, base moves to 7
    send_item(CmdAck, 32'hFFFF_FFFF);    // huge span
    send_item(CmdData, 32'd38);          // last slot
    send_item(CmdAck, 32'd39);           // span equals the window
    items_sent = 0;

    // Random part: start with one full window.
    run_batch(Window);
    while (items_sent < RandomItems) begin
      batch_no++;
      quiet <= (batch_no % 10 == 4);
      if (batch_no == 12) begin
        // Hold off until the window has drained every result.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if ($urandom_range(0, 99) < 85) run_batch(pick_batch_size());
      else repeat ($urandom_range(1, 4)) send_noise();
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d random packets and acks in %0d batches after the directed cases.",
             items_sent, batch_no);
    $display("Checked %0d results: %0d nack entries, %0d batches completed, %0d truncated.",
             checked, nacks, batches, truncs);
    if (fail_count == 0) begin
      $display("** multicast_nack_receiver_window: PASSED **");
    end else begin
      $display("** multicast_nack_receiver_window: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mnrw_pkg.sv
rtl/core/mnrw_alu.sv
rtl/core/mnrw_ctrl.sv
rtl/core/multicast_nack_receiver_window.sv
rtl/core/mnrw_checker.sv
test/mnrw_window_checker.sv
test/tb.sv
